// File: rtl/ftpp_pkg.sv
`timescale 1ns / 1ps

package ftpp_pkg;

    // Longest size field a control packet may carry, in bytes.
    localparam int SIZE_BYTES_MAX = 4;
    localparam int SizeLenW       = $clog2(SIZE_BYTES_MAX + 1);

    // Depth of the queue between parser and output stage.
    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);

    // Packet type and TLV tag codes.
    localparam logic [7:0] TYPE_DATA  = 8'h01;
    localparam logic [7:0] TYPE_START = 8'h02;
    localparam logic [7:0] TYPE_END   = 8'h03;
    localparam logic [7:0] TAG_SIZE   = 8'h00;
    localparam logic [7:0] TAG_NAME   = 8'h01;

    typedef enum logic [3:0] {
        PH_TYPE,
        PH_SIZE_TAG,
        PH_SIZE_LEN,
        PH_SIZE_VAL,
        PH_NAME_TAG,
        PH_NAME_LEN,
        PH_NAME,
        PH_SEQ,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_DROP
    } t_phase;

    typedef enum logic [2:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_NAME     = 3'd1,
        KIND_CTRL_HDR = 3'd2,
        KIND_DATA_HDR = 3'd3,
        KIND_ERROR    = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ERR_BAD_TYPE  = 2'd0,
        ERR_SIZE_TAG  = 2'd1,
        ERR_SIZE_LONG = 2'd2,
        ERR_NAME_TAG  = 2'd3
    } t_err;

    // One result word, fields not used by its kind are zero.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [31:0] file_size;
        logic [7:0]  name_length;
        logic        is_end;
        logic [7:0]  seq_number;
        logic [15:0] payload_length;
        t_err        error_code;
        logic        last;
    } t_result;

endpackage

// File: rtl/ftpp_in_if.sv
`timescale 1ns / 1ps

interface ftpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_first;

    modport source (output valid, output in_byte, output in_first, input ready);
    modport sink   (input valid, input in_byte, input in_first, output ready);
endinterface

// File: rtl/ftpp_out_if.sv
`timescale 1ns / 1ps

interface ftpp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  out_kind;
    logic [7:0]  out_byte;
    logic [31:0] file_size;
    logic [7:0]  name_length;
    logic        is_end;
    logic [7:0]  seq_number;
    logic [15:0] payload_length;
    logic [1:0]  error_code;
    logic        out_last;

    modport source (
        output valid, output out_kind, output out_byte, output file_size,
        output name_length, output is_end, output seq_number,
        output payload_length, output error_code, output out_last,
        input ready
    );
    modport sink (
        input valid, input out_kind, input out_byte, input file_size,
        input name_length, input is_end, input seq_number,
        input payload_length, input error_code, input out_last,
        output ready
    );
endinterface

// File: rtl/ftpp_front.sv
`timescale 1ns / 1ps

module ftpp_front import ftpp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ftpp_in_if.sink    i_in,
    input  logic       i_q_full,
    output logic       o_push,
    output t_result    o_rec
);

    t_phase                r_phase, n_phase, eff_phase, step_phase;
    logic [15:0]           r_byte_count, n_byte_count;
    logic [31:0]           r_size_accum, n_size_accum;
    logic [SizeLenW-1:0]   r_size_len, n_size_len;
    logic                  r_end_flag, n_end_flag;
    logic [7:0]            r_seq_hold, n_seq_hold;
    logic [7:0]            r_length_high, n_length_high;

    logic                  accept;
    logic                  emit;
    logic [7:0]            b;
    logic [15:0]           cnt_inc, cnt_dec, data_len;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.in_byte;
    assign eff_phase  = i_in.in_first ? PH_TYPE : r_phase;
    assign cnt_inc    = r_byte_count + 16'd1;
    assign cnt_dec    = r_byte_count - 16'd1;
    assign data_len   = {r_length_high, b};

    // next phase
    always_comb begin
        unique case (eff_phase)
            PH_TYPE: begin
                if (b == TYPE_DATA)                            step_phase = PH_SEQ;
                else if (b == TYPE_START || b == TYPE_END)     step_phase = PH_SIZE_TAG;
                else                                           step_phase = PH_DROP;
            end
            PH_SIZE_TAG: step_phase = (b == TAG_SIZE) ? PH_SIZE_LEN : PH_DROP;
            PH_SIZE_LEN: begin
                if (b > 8'(SIZE_BYTES_MAX)) step_phase = PH_DROP;
                else if (b == 8'd0)         step_phase = PH_NAME_TAG;
                else                        step_phase = PH_SIZE_VAL;
            end
            PH_SIZE_VAL: step_phase = (cnt_inc >= 16'(r_size_len)) ? PH_NAME_TAG : PH_SIZE_VAL;
            PH_NAME_TAG: step_phase = (b == TAG_NAME) ? PH_NAME_LEN : PH_DROP;
            PH_NAME_LEN: step_phase = (b == 8'd0) ? PH_TYPE : PH_NAME;
            PH_NAME:     step_phase = (cnt_dec == 16'd0) ? PH_TYPE : PH_NAME;
            PH_SEQ:      step_phase = PH_LEN_HI;
            PH_LEN_HI:   step_phase = PH_LEN_LO;
            PH_LEN_LO:   step_phase = (data_len == 16'd0) ? PH_TYPE : PH_PAYLOAD;
            PH_PAYLOAD:  step_phase = (cnt_dec == 16'd0) ? PH_TYPE : PH_PAYLOAD;
            PH_DROP:     step_phase = PH_DROP;
            default:     step_phase = PH_DROP;
        endcase
        n_phase = accept ? step_phase : r_phase;
    end

    // result word and field registers
    always_comb begin
        emit          = 1'b0;
        o_rec         = '0;
        n_byte_count  = r_byte_count;
        n_size_accum  = r_size_accum;
        n_size_len    = r_size_len;
        n_end_flag    = r_end_flag;
        n_seq_hold    = r_seq_hold;
        n_length_high = r_length_high;
        unique case (eff_phase)
            PH_TYPE: begin
                if (b == TYPE_START || b == TYPE_END) begin
                    n_end_flag = (b == TYPE_END);
                end else if (b != TYPE_DATA) begin
                    emit             = 1'b1;
                    o_rec.kind       = KIND_ERROR;
                    o_rec.error_code = ERR_BAD_TYPE;
                    o_rec.last       = 1'b1;
                end
            end
            PH_SIZE_TAG: begin
                if (b != TAG_SIZE) begin
                    emit             = 1'b1;
                    o_rec.kind       = KIND_ERROR;
                    o_rec.error_code = ERR_SIZE_TAG;
                    o_rec.last       = 1'b1;
                end
            end
            PH_SIZE_LEN: begin
                if (b > 8'(SIZE_BYTES_MAX)) begin
                    emit             = 1'b1;
                    o_rec.kind       = KIND_ERROR;
                    o_rec.error_code = ERR_SIZE_LONG;
                    o_rec.last       = 1'b1;
                end else begin
                    n_size_len   = b[SizeLenW-1:0];
                    n_size_accum = '0;
                    n_byte_count = '0;
                end
            end
            PH_SIZE_VAL: begin
                n_size_accum = {r_size_accum[23:0], b};
                n_byte_count = cnt_inc;
            end
            PH_NAME_TAG: begin
                if (b != TAG_NAME) begin
                    emit             = 1'b1;
                    o_rec.kind       = KIND_ERROR;
                    o_rec.error_code = ERR_NAME_TAG;
                    o_rec.last       = 1'b1;
                end
            end
            PH_NAME_LEN: begin
                emit              = 1'b1;
                o_rec.kind        = KIND_CTRL_HDR;
                o_rec.file_size   = r_size_accum;
                o_rec.name_length = b;
                o_rec.is_end      = r_end_flag;
                o_rec.last        = (b == 8'd0);
                if (b != 8'd0) n_byte_count = 16'(b);
            end
            PH_NAME, PH_PAYLOAD: begin
                emit         = 1'b1;
                o_rec.kind   = (eff_phase == PH_NAME) ? KIND_NAME : KIND_PAYLOAD;
                o_rec.data   = b;
                o_rec.last   = (cnt_dec == 16'd0);
                n_byte_count = cnt_dec;
            end
            PH_SEQ:    n_seq_hold    = b;
            PH_LEN_HI: n_length_high = b;
            PH_LEN_LO: begin
                emit                 = 1'b1;
                o_rec.kind           = KIND_DATA_HDR;
                o_rec.seq_number     = r_seq_hold;
                o_rec.payload_length = data_len;
                o_rec.last           = (data_len == 16'd0);
                if (data_len != 16'd0) n_byte_count = data_len;
            end
            PH_DROP: ;
            default: ;
        endcase
        o_push = accept && emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_TYPE;
            r_byte_count  <= '0;
            r_size_accum  <= '0;
            r_size_len    <= '0;
            r_end_flag    <= 1'b0;
            r_seq_hold    <= '0;
            r_length_high <= '0;
        end else begin
            r_phase <= n_phase;
            if (accept) begin
                r_byte_count  <= n_byte_count;
                r_size_accum  <= n_size_accum;
                r_size_len    <= n_size_len;
                r_end_flag    <= n_end_flag;
                r_seq_hold    <= n_seq_hold;
                r_length_high <= n_length_high;
            end
        end
    end

endmodule

// File: rtl/ftpp_queue.sv
`timescale 1ns / 1ps

module ftpp_queue import ftpp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_rec,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_empty,
    output t_result o_rec
);

    t_result            r_mem [QueueDepth];
    logic [QPtrW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPtrW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QPtrW:0]     r_count, n_count;

    assign o_full  = (r_count == (QPtrW+1)'(QueueDepth));
    assign o_empty = (r_count == '0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (QPtrW+1)'(i_push) - (QPtrW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// File: rtl/ftpp_back.sv
`timescale 1ns / 1ps

module ftpp_back import ftpp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rec_valid,
    input  t_result    i_rec,
    output logic       o_pop,
    ftpp_out_if.source o_out
);

    logic    r_valid, n_valid;
    t_result r_rec;
    logic    load;

    // refill the output register whenever it is empty or being drained
    assign load  = i_rec_valid && (!r_valid || o_out.ready);
    assign o_pop = load;

    always_comb begin
        if (load)             n_valid = 1'b1;
        else if (o_out.ready) n_valid = 1'b0;
        else                  n_valid = r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= n_valid;
    end

    always_ff @(posedge i_clk) begin
        if (load) r_rec <= i_rec;
    end

    assign o_out.valid          = r_valid;
    assign o_out.out_kind       = r_rec.kind;
    assign o_out.out_byte       = r_rec.data;
    assign o_out.file_size      = r_rec.file_size;
    assign o_out.name_length    = r_rec.name_length;
    assign o_out.is_end         = r_rec.is_end;
    assign o_out.seq_number     = r_rec.seq_number;
    assign o_out.payload_length = r_rec.payload_length;
    assign o_out.error_code     = r_rec.error_code;
    assign o_out.out_last       = r_rec.last;

endmodule

// File: rtl/file_transfer_packet_parser.sv
`timescale 1ns / 1ps

// channel | dir | modport | word contents
// i_in    | in  | sink    | in_byte, in_first
// o_out   | out | source  | out_kind, out_byte, file_size, name_length, is_end,
//         |     |         | seq_number, payload_length, error_code, out_last
//
// One byte per cycle while the result queue has room. The parser FSM steps once per accepted byte.
// A result word reaches o_out from its byte through the queue and the out reg.
// Synchronous active-low reset; parser waits for a type byte afterwards.
// i_in.ready drops only when the 4-entry result queue is full, i.e. under a
// long o_out stall; bytes that yield no result still need a free slot.

module file_transfer_packet_parser import ftpp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ftpp_in_if.sink    i_in,
    ftpp_out_if.source o_out
);

    // parser -> queue
    logic    push;
    t_result push_rec;
    logic    q_full;

    // queue -> output stage
    logic    q_empty;
    logic    pop;
    t_result head_rec;

    // front: byte-serial packet FSM, builds one result word per emitting byte
    ftpp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_rec    (push_rec)
    );

    // short FIFO decouples parsing from downstream stalls
    ftpp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_rec   (head_rec)
    );

    // back: registered output word
    ftpp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (!q_empty),
        .i_rec       (head_rec),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

// File: test/ftpp_result_checker.sv
`timescale 1ns / 1ps

module ftpp_result_checker import ftpp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ftpp_in_if   i_in_mon,
    ftpp_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);

    // Parser state, mirrored from the accepted byte stream
    t_phase      phase;
    logic [15:0] byte_count;
    logic [31:0] size_accum;
    logic [7:0]  size_len;
    logic        end_flag;
    logic [7:0]  seq_hold;
    logic [7:0]  length_high;

    t_result expected_words[$];
    int      mismatch_count;

    assign o_fail_count = mismatch_count;

    function automatic t_result flag_error(input t_err code);
        t_result r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        r.last       = 1'b1;
        phase        = PH_DROP;
        return r;
    endfunction

    // Steps the parser by one byte; returns 1 when the byte yields a word.
    function automatic bit decode_byte(input logic [7:0] b, input logic first,
                                       output t_result r);
        bit hit;
        hit = 1'b0;
        r   = '0;
        if (first) phase = PH_TYPE;
        case (phase)
            PH_TYPE: begin
                if (b == TYPE_DATA) begin
                    phase = PH_SEQ;
                end else if (b == TYPE_START || b == TYPE_END) begin
                    end_flag = (b == TYPE_END);
                    phase    = PH_SIZE_TAG;
                end else begin
                    r   = flag_error(ERR_BAD_TYPE);
                    hit = 1'b1;
                end
            end
            PH_SIZE_TAG: begin
                if (b != TAG_SIZE) begin
                    r   = flag_error(ERR_SIZE_TAG);
                    hit = 1'b1;
                end else begin
                    phase = PH_SIZE_LEN;
                end
            end
            PH_SIZE_LEN: begin
                if (b > SIZE_BYTES_MAX) begin
                    r   = flag_error(ERR_SIZE_LONG);
                    hit = 1'b1;
                end else begin
                    size_len   = b;
                    size_accum = '0;
                    byte_count = '0;
                    phase      = (b == 8'd0) ? PH_NAME_TAG : PH_SIZE_VAL;
                end
            end
            PH_SIZE_VAL: begin
                size_accum = {size_accum[23:0], b};
                byte_count = byte_count + 16'd1;
                if (byte_count >= {8'd0, size_len}) phase = PH_NAME_TAG;
            end
            PH_NAME_TAG: begin
                if (b != TAG_NAME) begin
                    r   = flag_error(ERR_NAME_TAG);
                    hit = 1'b1;
                end else begin
                    phase = PH_NAME_LEN;
                end
            end
            PH_NAME_LEN: begin
                r.kind        = KIND_CTRL_HDR;
                r.file_size   = size_accum;
                r.name_length = b;
                r.is_end      = end_flag;
                hit           = 1'b1;
                if (b == 8'd0) begin
                    r.last = 1'b1;
                    phase  = PH_TYPE;
                end else begin
                    byte_count = {8'd0, b};
                    phase      = PH_NAME;
                end
            end
            PH_NAME: begin
                r.kind     = KIND_NAME;
                r.data     = b;
                hit        = 1'b1;
                byte_count = byte_count - 16'd1;
                if (byte_count == 16'd0) begin
                    r.last = 1'b1;
                    phase  = PH_TYPE;
                end
            end
            PH_SEQ: begin
                seq_hold = b;
                phase    = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                length_high = b;
                phase       = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                r.kind           = KIND_DATA_HDR;
                r.seq_number     = seq_hold;
                r.payload_length = {length_high, b};
                hit              = 1'b1;
                if ({length_high, b} == 16'd0) begin
                    r.last = 1'b1;
                    phase  = PH_TYPE;
                end else begin
                    byte_count = {length_high, b};
                    phase      = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                r.kind     = KIND_PAYLOAD;
                r.data     = b;
                hit        = 1'b1;
                byte_count = byte_count - 16'd1;
                if (byte_count == 16'd0) begin
                    r.last = 1'b1;
                    phase  = PH_TYPE;
                end
            end
            default: begin
                phase = PH_DROP;
            end
        endcase
        return hit;
    endfunction

    function automatic string fmt_word(input t_result w);
        return $sformatf({"kind=%0d byte=%02h size=%08h nlen=%0d end=%0b ",
                          "seq=%02h plen=%0d err=%0d last=%0b"},
                         w.kind, w.data, w.file_size, w.name_length, w.is_end,
                         w.seq_number, w.payload_length, w.error_code, w.last);
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result pred;
        if (!i_rst_n) begin
            phase          = PH_TYPE;
            byte_count     = '0;
            size_accum     = '0;
            size_len       = '0;
            end_flag       = 1'b0;
            seq_hold       = '0;
            length_high    = '0;
            mismatch_count = 0;
            expected_words.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.kind           = t_kind'(i_out_mon.out_kind);
                got.data           = i_out_mon.out_byte;
                got.file_size      = i_out_mon.file_size;
                got.name_length    = i_out_mon.name_length;
                got.is_end         = i_out_mon.is_end;
                got.seq_number     = i_out_mon.seq_number;
                got.payload_length = i_out_mon.payload_length;
                got.error_code     = t_err'(i_out_mon.error_code);
                got.last           = i_out_mon.out_last;
                if (expected_words.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected word: %s", fmt_word(got));
                    mismatch_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (got.kind !== want.kind || got.data !== want.data ||
                        got.file_size !== want.file_size ||
                        got.name_length !== want.name_length ||
                        got.is_end !== want.is_end ||
                        got.seq_number !== want.seq_number ||
                        got.payload_length !== want.payload_length ||
                        got.error_code !== want.error_code || got.last !== want.last) begin
                        if (mismatch_count < 10) begin
                            $display("mismatch expected: %s", fmt_word(want));
                            $display("mismatch actual:   %s", fmt_word(got));
                        end
                        mismatch_count++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                if (decode_byte(i_in_mon.in_byte, i_in_mon.in_first, pred))
                    expected_words.push_back(pred);
            end
        end
        o_pending <= expected_words.size();
    end

endmodule

// File: test/file_transfer_packet_parser_tb.sv
`timescale 1ns / 1ps

module file_transfer_packet_parser_tb import ftpp_pkg::*; ();

    // Receiver hold-off used to fill the result queue and back up the input.
    localparam int HOLD_CYCLES  = 300;
    // Words per random phase; three phases give roughly the item budget.
    localparam int PHASE_WORDS  = 330;
    // Cycles to keep watching after the last expected word, for any stray
    // word still in the parser -> queue -> out path.
    localparam int DRAIN_CYCLES = 12;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int fail_count;
    int pending;

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    bit need_first;
    int words_sent;

    // Packet under construction, sent byte by byte.
    logic [7:0] pkt[$];

    ftpp_in_if  in_ch ();
    ftpp_out_if out_ch ();

    file_transfer_packet_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Watches both channels, predicts every word and compares.
    ftpp_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop, far beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // Receiver side: random ready, or a long counted hold-off on request.
    initial begin
        int hold_cnt;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one word, idling at random first; returns in the step of acceptance.
    task automatic send_word(input logic [7:0] b, input logic f);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.in_byte  <= b;
        in_ch.in_first <= f;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        words_sent++;
    endtask

    // Send the first cut bytes of pkt; the first-byte flag only on the type byte.
    task automatic send_pkt(input logic first, input int cut);
        for (int i = 0; i < cut; i++)
            send_word(pkt[i], first && (i == 0));
    endtask

    function automatic void build_data(input logic [7:0] seq, input logic [15:0] len);
        pkt.delete();
        pkt.push_back(TYPE_DATA);
        pkt.push_back(seq);
        pkt.push_back(len[15:8]);
        pkt.push_back(len[7:0]);
        for (int i = 0; i < len; i++) pkt.push_back(8'($urandom));
    endfunction

    // Control packet: type, size TLV (big-endian), name TLV.
    // Offsets: 0 type, 1 size tag, 2 size length, 3 + size_bytes name tag.
    function automatic void build_ctrl(input logic [7:0] kind_byte, input int size_bytes,
                                       input logic [31:0] size_val, input int name_len);
        pkt.delete();
        pkt.push_back(kind_byte);
        pkt.push_back(TAG_SIZE);
        pkt.push_back(size_bytes[7:0]);
        for (int i = size_bytes - 1; i >= 0; i--) pkt.push_back(size_val[8*i +: 8]);
        pkt.push_back(TAG_NAME);
        pkt.push_back(name_len[7:0]);
        for (int i = 0; i < name_len; i++) pkt.push_back(8'($urandom));
    endfunction

    // Mostly short bodies, a few long ones so the length high byte moves.
    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(0, 6);
        if (r < 95) return $urandom_range(7, 40);
        return $urandom_range(41, 300);
    endfunction

    task automatic random_packet();
        int  pick;
        int  sub;
        int  sz;
        int  nl;
        int  cut;
        int  v;
        logic f;
        pick = $urandom_range(99);
        // Packets delimit themselves, so a clean predecessor lets the flag go
        f  = need_first || ($urandom_range(99) < 80);
        sz = $urandom_range(0, SIZE_BYTES_MAX);
        nl = pick_len();
        if (nl > 255) nl = 255;
        need_first = 1'b0;
        if (pick < 40) begin
            build_data(8'($urandom), 16'(pick_len()));
        end else if (pick < 80) begin
            build_ctrl($urandom_range(1) ? TYPE_END : TYPE_START, sz, $urandom, nl);
        end else begin
            // broken packets and plain noise; the parser needs a flag after these
            need_first = 1'b1;
            sub        = $urandom_range(4);
            f          = 1'b1;
            case (sub)
                0: begin
                    // noise with random flags anywhere
                    repeat ($urandom_range(1, 8))
                        send_word(8'($urandom), 1'($urandom_range(1)));
                    return;
                end
                1: begin
                    build_data(8'($urandom), 16'($urandom_range(0, 4)));
                    v      = $urandom_range(0, 252);
                    pkt[0] = (v == 0) ? 8'h00 : v[7:0] + 8'd3;
                end
                2: begin
                    build_ctrl(TYPE_START, sz, $urandom, 2);
                    pkt[1] = 8'($urandom_range(1, 255));
                end
                3: begin
                    build_ctrl(TYPE_END, 0, 0, 2);
                    pkt[2] = 8'($urandom_range(SIZE_BYTES_MAX + 1, 255));
                end
                default: begin
                    build_ctrl(TYPE_START, sz, $urandom, 2);
                    pkt[3 + sz] = $urandom_range(1) ? 8'h00 : 8'($urandom_range(2, 255));
                end
            endcase
        end
        cut = pkt.size();
        // Now and then abandon a good packet part way through
        if (pick < 80 && $urandom_range(99) < 10) begin
            cut        = $urandom_range(1, pkt.size());
            need_first = 1'b1;
        end
        send_pkt(f, cut);
    endtask

    task automatic run_random(input int n);
        int target;
        target = words_sent + n;
        while (words_sent < target) random_packet();
    endtask

    initial begin
        in_ch.valid    <= 1'b0;
        in_ch.in_byte  <= 8'h00;
        in_ch.in_first <= 1'b0;
        i_rst_n        <= 1'b0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        hold_req       = 1'b0;
        need_first     = 1'b0;
        words_sent     = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        // no first flag right after reset: still parsed as a type byte
        build_data(8'h5A, 16'd2);
        send_pkt(1'b0, pkt.size());
        // empty payload: header carries last
        build_data(8'hFF, 16'd0);
        send_pkt(1'b1, pkt.size());
        // zero-length size field and empty name
        build_ctrl(TYPE_START, 0, 32'h0, 0);
        send_pkt(1'b1, pkt.size());
        // widest size field, all ones, end packet; follows without a flag
        build_ctrl(TYPE_END, SIZE_BYTES_MAX, 32'hFFFF_FFFF, 2);
        send_pkt(1'b0, pkt.size());
        // bad type, then bytes that must be dropped until the next flag
        send_word(8'h00, 1'b1);
        send_word(TYPE_DATA, 1'b0);
        send_word(8'hA5, 1'b0);
        send_word(8'hFF, 1'b1);
        // bad size tag
        build_ctrl(TYPE_START, 1, 32'h7, 1);
        pkt[1] = 8'hFF;
        send_pkt(1'b1, 2);
        // size field one byte too long
        build_ctrl(TYPE_START, 1, 32'h7, 1);
        pkt[2] = 8'(SIZE_BYTES_MAX + 1);
        send_pkt(1'b1, 3);
        // bad name tag
        build_ctrl(TYPE_END, 1, 32'h12, 1);
        pkt[4] = 8'h00;
        send_pkt(1'b1, 5);
        // largest payload length, abandoned by a new flag mid-packet
        pkt = '{TYPE_DATA, 8'h80, 8'hFF, 8'hFF, 8'h11, 8'h22};
        send_pkt(1'b1, pkt.size());
        // largest name length, abandoned after three name bytes
        build_ctrl(TYPE_START, 2, 32'h0100, 255);
        send_pkt(1'b1, 10);
        build_data(8'h00, 16'd1);
        send_pkt(1'b1, pkt.size());

        // ---- random part ----
        need_first    = 1'b0;
        send_idle_pct = 8;
        recv_idle_pct = 62;
        run_random(PHASE_WORDS);

        send_idle_pct = 62;
        recv_idle_pct = 8;
        run_random(PHASE_WORDS);

        // no idling; receiver stalls long enough to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        run_random(PHASE_WORDS);

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
